// ===== rtl/dlle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlle_pkg
// Shared constants and types of the linked list engine: request kinds,
// status codes and the request class passed from front end to back end.
// ----------------------------------------------------------------------------
package dlle_pkg;

	localparam int POOL_NODES_DEF = 16;
	localparam int DATA_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_BACK     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_BACK      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INSERT_BEFORE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERASE         = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd3;

	typedef enum logic [1:0] {
		OP_NOP    = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// which node the request works at
	typedef enum logic [1:0] {
		SEL_SENTINEL = 2'd0,
		SEL_HEAD     = 2'd1,
		SEL_TAIL     = 2'd2,
		SEL_TARGET   = 2'd3
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
		logic bad_handle;
	} cls_t;

endpackage
`default_nettype wire

// ===== rtl/doubly_linked_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Circular doubly linked list in a fixed node pool, node 0 as sentinel.
// ----------------------------------------------------------------------------
// Request channel: kind, value and target_node are taken at a rising edge
// with start high and busy low. Requests wait in a two-entry queue; busy is
// high while the queue is full.
// Result channel: status, new_node, removed_value and element_count are valid
// for exactly one cycle while done is high. The receiver cannot stall, so
// results never back up.
// Short requests (pops, erases, failed or unknown requests) finish in state
// B_CHECK; successful pushes and inserts go on through B_ALLOC and B_LINK.
// The sequencer works on one request at a time, while the queue keeps
// taking requests until it is full. It reads the neighbor links and
// the allocation bitmap word, then writes back through the single write port
// of each link memory, one link per memory per cycle.
// Reset empties the list at once: sentinel links and allocation state are
// flops, node memories need no clearing pass. busy is low after reset.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
	parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF,
	parameter int DATA_BITS  = dlle_pkg::DATA_BITS_DEF,
	localparam int NODE_BITS = $clog2(POOL_NODES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dlle_pkg::KIND_W-1:0]   kind,
	input  logic signed [DATA_BITS-1:0]   value,
	input  logic [NODE_BITS-1:0]          target_node,
	output logic                          done,
	output logic [dlle_pkg::STATUS_W-1:0] status,
	output logic [NODE_BITS-1:0]          new_node,
	output logic signed [DATA_BITS-1:0]   removed_value,
	output logic [NODE_BITS-1:0]          element_count
);

	localparam int Q_WIDTH = $bits(dlle_pkg::cls_t) + DATA_BITS + NODE_BITS;

	logic                 q_full, q_valid, q_pop, push;
	dlle_pkg::cls_t       push_cls, pop_cls;
	logic [DATA_BITS-1:0] push_value, pop_value;
	logic [NODE_BITS-1:0] push_target, pop_target;
	logic [Q_WIDTH-1:0]   pop_data;

	dlle_front #(.POOL_NODES(POOL_NODES), .DATA_BITS(DATA_BITS)) u_front (
		.start(start),
		.kind(kind),
		.value(value),
		.target_node(target_node),
		.q_full(q_full),
		.busy(busy),
		.push(push),
		.push_cls(push_cls),
		.push_value(push_value),
		.push_target(push_target)
	);

	dlle_queue #(.WIDTH(Q_WIDTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_cls, push_value, push_target}),
		.full(q_full),
		.pop(q_pop),
		.pop_data(pop_data),
		.valid(q_valid)
	);

	assign {pop_cls, pop_value, pop_target} = pop_data;

	dlle_back #(.POOL_NODES(POOL_NODES), .DATA_BITS(DATA_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cls(pop_cls),
		.q_value(pop_value),
		.q_target(pop_target),
		.q_pop(q_pop),
		.done(done),
		.status(status),
		.new_node(new_node),
		.removed_value(removed_value),
		.element_count(element_count)
	);

endmodule
`default_nettype wire

// ===== rtl/dlle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlle_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dlle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/dlle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlle_front
// Request intake: takes an item when the queue has room, decodes its kind
// into an operation and a working position, and range checks the handle.
// ----------------------------------------------------------------------------
module dlle_front #(
	parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF,
	parameter int DATA_BITS  = dlle_pkg::DATA_BITS_DEF,
	localparam int NODE_BITS = $clog2(POOL_NODES)
) (
	input  logic                        start,
	input  logic [dlle_pkg::KIND_W-1:0] kind,
	input  logic [DATA_BITS-1:0]        value,
	input  logic [NODE_BITS-1:0]        target_node,
	input  logic                        q_full,
	output logic                        busy,
	output logic                        push,
	output dlle_pkg::cls_t              push_cls,
	output logic [DATA_BITS-1:0]        push_value,
	output logic [NODE_BITS-1:0]        push_target
);

	logic in_range;

	assign in_range = ({1'b0, target_node} < (NODE_BITS+1)'(POOL_NODES));

	always_comb begin
		push_cls.op         = dlle_pkg::OP_NOP;
		push_cls.sel        = dlle_pkg::SEL_SENTINEL;
		push_cls.bad_handle = 1'b0;
		unique case (kind)
			dlle_pkg::KIND_PUSH_BACK: begin
				push_cls.op  = dlle_pkg::OP_INSERT;
				push_cls.sel = dlle_pkg::SEL_SENTINEL;
			end
			dlle_pkg::KIND_PUSH_FRONT: begin
				push_cls.op  = dlle_pkg::OP_INSERT;
				push_cls.sel = dlle_pkg::SEL_HEAD;
			end
			dlle_pkg::KIND_POP_BACK: begin
				push_cls.op  = dlle_pkg::OP_REMOVE;
				push_cls.sel = dlle_pkg::SEL_TAIL;
			end
			dlle_pkg::KIND_POP_FRONT: begin
				push_cls.op  = dlle_pkg::OP_REMOVE;
				push_cls.sel = dlle_pkg::SEL_HEAD;
			end
			dlle_pkg::KIND_INSERT_BEFORE: begin
				push_cls.op         = dlle_pkg::OP_INSERT;
				push_cls.sel        = dlle_pkg::SEL_TARGET;
				push_cls.bad_handle = !in_range;
			end
			dlle_pkg::KIND_ERASE: begin
				// the sentinel can never be erased
				push_cls.op         = dlle_pkg::OP_REMOVE;
				push_cls.sel        = dlle_pkg::SEL_TARGET;
				push_cls.bad_handle = !in_range || (target_node == '0);
			end
			default: begin
				push_cls.op = dlle_pkg::OP_NOP;
			end
		endcase
	end

	// out of range handles are parked on the sentinel so memories stay in range
	assign push_target = in_range ? target_node : '0;
	assign push_value  = value;
	assign busy        = q_full;
	assign push        = start && !q_full;

endmodule
`default_nettype wire

// ===== rtl/dlle_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlle_queue
// Short first-in first-out queue that decouples request intake from the
// list update sequencer.
// ----------------------------------------------------------------------------
module dlle_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	localparam int DEPTH = dlle_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_q];
	assign valid    = (cnt_q != '0);
	assign full     = (cnt_q == CNT_W'(DEPTH));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid))
		else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== rtl/dlle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlle_back
// List update sequencer: reads the neighbor links and the allocation bitmap,
// checks the request, allocates the lowest free node and rewires the links.
// ----------------------------------------------------------------------------
module dlle_back #(
	parameter int POOL_NODES = dlle_pkg::POOL_NODES_DEF,
	parameter int DATA_BITS  = dlle_pkg::DATA_BITS_DEF,
	localparam int NODE_BITS = $clog2(POOL_NODES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  dlle_pkg::cls_t                q_cls,
	input  logic [DATA_BITS-1:0]          q_value,
	input  logic [NODE_BITS-1:0]          q_target,
	output logic                          q_pop,
	output logic                          done,
	output logic [dlle_pkg::STATUS_W-1:0] status,
	output logic [NODE_BITS-1:0]          new_node,
	output logic signed [DATA_BITS-1:0]   removed_value,
	output logic [NODE_BITS-1:0]          element_count
);

	localparam int WBIT_W    = (NODE_BITS < 5) ? NODE_BITS : 5;
	localparam int WORD_BITS = 1 << WBIT_W;
	localparam int WORDS     = (POOL_NODES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [NODE_BITS-1:0] LAST_COUNT = NODE_BITS'(POOL_NODES - 1);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_LOOK  = 5'b00010,
		B_CHECK = 5'b00100,
		B_ALLOC = 5'b01000,
		B_LINK  = 5'b10000
	} bstate_t;

	function automatic logic [WIDX_W-1:0] word_of(input logic [NODE_BITS-1:0] n);
		logic [NODE_BITS-1:0] s;
		s = n >> WBIT_W;
		return s[WIDX_W-1:0];
	endfunction

	function automatic logic [NODE_BITS-1:0] node_at(input logic [WIDX_W-1:0] w,
			input logic [WBIT_W-1:0] b);
		logic [NODE_BITS-1:0] r;
		r = (NODE_BITS'(w) << WBIT_W) | NODE_BITS'(b);
		return r;
	endfunction

	// bitmap word before its first write: sentinel and nonexistent nodes taken
	function automatic logic [WORD_BITS-1:0] rsv_mask(input logic [WIDX_W-1:0] w);
		logic [WORD_BITS-1:0] m;
		int idx;
		for (int b = 0; b < WORD_BITS; b++) begin
			idx  = (int'(w) << WBIT_W) + b;
			m[b] = (idx == 0) || (idx >= POOL_NODES);
		end
		return m;
	endfunction

	bstate_t state_q, state_d;
	dlle_pkg::cls_t cls_q, cls_d;
	logic [DATA_BITS-1:0] val_q, val_d;
	logic [NODE_BITS-1:0] node_q, node_d, p_q, p_d, nn_q, nn_d;
	logic [WIDX_W-1:0] fw_q, fw_d;
	logic [NODE_BITS-1:0] count_q, count_d, head_q, head_d, tail_q, tail_d;
	logic [WORDS-1:0] full_q, full_d, wvld_q, wvld_d;
	logic done_q, done_d;
	logic [dlle_pkg::STATUS_W-1:0] status_q, status_d;
	logic [NODE_BITS-1:0] new_node_q, new_node_d;
	logic signed [DATA_BITS-1:0] removed_q, removed_d;

	logic                 val_we, prv_we, nxt_we, bm_we;
	logic [NODE_BITS-1:0] val_waddr, prv_waddr, nxt_waddr;
	logic [DATA_BITS-1:0] val_wdata, val_rdata;
	logic [NODE_BITS-1:0] prv_wdata, nxt_wdata, prv_rdata, nxt_rdata;
	logic [WIDX_W-1:0]    bm_waddr, bm_raddr;
	logic [WORD_BITS-1:0] bm_wdata, bm_rdata;

	logic [WIDX_W-1:0]    node_widx, free_word;
	logic [WBIT_W-1:0]    node_bit, free_bit;
	logic [WORD_BITS-1:0] node_word, alloc_word, alloc_next;
	logic [NODE_BITS-1:0] link_p, link_n, alloc_node;
	logic                 in_use;

	dlle_ram #(.WIDTH(DATA_BITS), .DEPTH(POOL_NODES)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.raddr(node_q), .rdata(val_rdata)
	);

	dlle_ram #(.WIDTH(NODE_BITS), .DEPTH(POOL_NODES)) u_prv_ram (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(node_q), .rdata(prv_rdata)
	);

	dlle_ram #(.WIDTH(NODE_BITS), .DEPTH(POOL_NODES)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(node_q), .rdata(nxt_rdata)
	);

	dlle_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_bm_ram (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	// lowest bitmap word that still has a free node
	always_comb begin
		free_word = '0;
		for (int w = WORDS - 1; w >= 0; w--) begin
			if (!full_q[w]) begin
				free_word = WIDX_W'(w);
			end
		end
	end

	// lowest free node inside that word
	always_comb begin
		free_bit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!alloc_word[b]) begin
				free_bit = WBIT_W'(b);
			end
		end
	end

	assign node_widx  = word_of(node_q);
	assign node_bit   = node_q[WBIT_W-1:0];
	assign node_word  = wvld_q[node_widx] ? bm_rdata : rsv_mask(node_widx);
	assign in_use     = node_word[node_bit];
	// sentinel links live in head_q / tail_q
	assign link_p     = (node_q == '0) ? tail_q : prv_rdata;
	assign link_n     = (node_q == '0) ? head_q : nxt_rdata;
	assign alloc_word = wvld_q[fw_q] ? bm_rdata : rsv_mask(fw_q);
	assign alloc_node = node_at(fw_q, free_bit);
	assign alloc_next = alloc_word | (WORD_BITS'(1) << free_bit);
	assign bm_raddr   = (state_q == B_CHECK) ? fw_q : node_widx;

	always_comb begin
		state_d    = state_q;
		cls_d      = cls_q;
		val_d      = val_q;
		node_d     = node_q;
		p_d        = p_q;
		nn_d       = nn_q;
		fw_d       = fw_q;
		count_d    = count_q;
		head_d     = head_q;
		tail_d     = tail_q;
		full_d     = full_q;
		wvld_d     = wvld_q;
		done_d     = 1'b0;
		status_d   = status_q;
		new_node_d = new_node_q;
		removed_d  = removed_q;
		q_pop      = 1'b0;
		val_we     = 1'b0;
		val_waddr  = '0;
		val_wdata  = '0;
		prv_we     = 1'b0;
		prv_waddr  = '0;
		prv_wdata  = '0;
		nxt_we     = 1'b0;
		nxt_waddr  = '0;
		nxt_wdata  = '0;
		bm_we      = 1'b0;
		bm_waddr   = '0;
		bm_wdata   = '0;

		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					cls_d = q_cls;
					val_d = q_value;
					case (q_cls.sel)
						dlle_pkg::SEL_SENTINEL: node_d = '0;
						dlle_pkg::SEL_HEAD:     node_d = head_q;
						dlle_pkg::SEL_TAIL:     node_d = tail_q;
						default:                node_d = q_target;
					endcase
					state_d = B_LOOK;
				end
			end
			B_LOOK: begin
				fw_d    = free_word;
				state_d = B_CHECK;
			end
			B_CHECK: begin
				state_d    = B_IDLE;
				done_d     = 1'b1;
				status_d   = dlle_pkg::ST_OK;
				new_node_d = '0;
				removed_d  = '0;
				unique case (cls_q.op)
					dlle_pkg::OP_REMOVE: begin
						if (cls_q.sel == dlle_pkg::SEL_TARGET &&
								(cls_q.bad_handle || !in_use)) begin
							status_d = dlle_pkg::ST_BAD_NODE;
						end else if (cls_q.sel != dlle_pkg::SEL_TARGET &&
								count_q == '0) begin
							status_d = dlle_pkg::ST_EMPTY;
						end else begin
							removed_d         = val_rdata;
							bm_we             = 1'b1;
							bm_waddr          = node_widx;
							bm_wdata          = node_word & ~(WORD_BITS'(1) << node_bit);
							wvld_d[node_widx] = 1'b1;
							full_d[node_widx] = 1'b0;
							if (link_p == '0) begin
								head_d = link_n;
							end else begin
								nxt_we    = 1'b1;
								nxt_waddr = link_p;
								nxt_wdata = link_n;
							end
							if (link_n == '0) begin
								tail_d = link_p;
							end else begin
								prv_we    = 1'b1;
								prv_waddr = link_n;
								prv_wdata = link_p;
							end
							count_d = count_q - 1'b1;
						end
					end
					dlle_pkg::OP_INSERT: begin
						// handle is checked before the pool
						if (cls_q.sel == dlle_pkg::SEL_TARGET &&
								(cls_q.bad_handle || !in_use)) begin
							status_d = dlle_pkg::ST_BAD_NODE;
						end else if (count_q == LAST_COUNT) begin
							status_d = dlle_pkg::ST_FULL;
						end else begin
							done_d  = 1'b0;
							p_d     = link_p;
							state_d = B_ALLOC;
						end
					end
					default: begin
						status_d = dlle_pkg::ST_OK;
					end
				endcase
			end
			B_ALLOC: begin
				bm_we        = 1'b1;
				bm_waddr     = fw_q;
				bm_wdata     = alloc_next;
				wvld_d[fw_q] = 1'b1;
				full_d[fw_q] = &alloc_next;
				val_we       = 1'b1;
				val_waddr    = alloc_node;
				val_wdata    = val_q;
				prv_we       = 1'b1;
				prv_waddr    = alloc_node;
				prv_wdata    = p_q;
				nxt_we       = 1'b1;
				nxt_waddr    = alloc_node;
				nxt_wdata    = node_q;
				nn_d         = alloc_node;
				state_d      = B_LINK;
			end
			B_LINK: begin
				if (p_q == '0) begin
					head_d = nn_q;
				end else begin
					nxt_we    = 1'b1;
					nxt_waddr = p_q;
					nxt_wdata = nn_q;
				end
				if (node_q == '0) begin
					tail_d = nn_q;
				end else begin
					prv_we    = 1'b1;
					prv_waddr = node_q;
					prv_wdata = nn_q;
				end
				count_d    = count_q + 1'b1;
				done_d     = 1'b1;
				status_d   = dlle_pkg::ST_OK;
				new_node_d = nn_q;
				removed_d  = '0;
				state_d    = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			full_q  <= '0;
			wvld_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			full_q  <= full_d;
			wvld_q  <= wvld_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cls_q      <= cls_d;
		val_q      <= val_d;
		node_q     <= node_d;
		p_q        <= p_d;
		nn_q       <= nn_d;
		fw_q       <= fw_d;
		status_q   <= status_d;
		new_node_q <= new_node_d;
		removed_q  <= removed_d;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign new_node      = new_node_q;
	assign removed_value = removed_q;
	assign element_count = count_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_COUNT)
		else $error("element count beyond pool capacity");

	a_empty_links: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == ((head_q == '0) && (tail_q == '0)))
		else $error("sentinel links disagree with element count");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != dlle_pkg::ST_OK) |-> (new_node_q == '0 && removed_q == '0))
		else $error("failed request reports a node or a value");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for doubly_linked_list_engine
// Drives list requests through the start/busy handshake and keeps its own
// copy of the node pool and its links. Every done strobe is compared, field
// by field, with the oldest predicted answer.
// ----------------------------------------------------------------------------
module testbench;
	import dlle_pkg::*;

	localparam int NODES = POOL_NODES_DEF;
	localparam int DBITS = DATA_BITS_DEF;
	localparam int NB    = $clog2(NODES);

	// kinds the block has to ignore
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	localparam int RANDOM_ITEMS = 950;
	localparam int CALM_TAIL    = 150;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NB-1:0]       new_node;
		logic [DBITS-1:0]    removed_value;
		logic [NB-1:0]       element_count;
	} list_answer_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [KIND_W-1:0]        kind = '0;
	logic signed [DBITS-1:0]  value = '0;
	logic [NB-1:0]            target_node = '0;
	logic                     busy;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [NB-1:0]            new_node;
	logic signed [DBITS-1:0]  removed_value;
	logic [NB-1:0]            element_count;

	// predicted list state
	logic [DBITS-1:0] node_data [NODES];
	logic [NB-1:0]    prev_of [NODES];
	logic [NB-1:0]    next_of [NODES];
	logic             node_used [NODES];
	int               list_len;

	list_answer_t pending_answers[$];
	int           mismatches = 0;

	doubly_linked_list_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.value         (value),
		.target_node   (target_node),
		.done          (done),
		.status        (status),
		.new_node      (new_node),
		.removed_value (removed_value),
		.element_count (element_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("doubly_linked_list_engine: mismatch");
		$finish;
	end

	function automatic logic [STATUS_W-1:0] link_before(input logic [NB-1:0] at,
			input logic [DBITS-1:0] v, output logic [NB-1:0] made);
		logic [NB-1:0] n;
		logic [NB-1:0] p;
		n = '0;
		made = '0;
		// scan downward so the lowest free node wins
		for (int i = NODES - 1; i >= 1; i--)
			if (!node_used[i])
				n = NB'(i);
		if (n == 0)
			return ST_FULL;
		p = prev_of[at];
		node_data[n] = v;
		node_used[n] = 1'b1;
		prev_of[n] = p;
		next_of[n] = at;
		next_of[p] = n;
		prev_of[at] = n;
		list_len++;
		made = n;
		return ST_OK;
	endfunction

	function automatic logic [DBITS-1:0] unlink_node(input logic [NB-1:0] n);
		logic [NB-1:0] p;
		logic [NB-1:0] q;
		p = prev_of[n];
		q = next_of[n];
		next_of[p] = q;
		prev_of[q] = p;
		node_used[n] = 1'b0;
		list_len--;
		return node_data[n];
	endfunction

	function automatic list_answer_t apply_request(input logic [KIND_W-1:0] k,
			input logic [DBITS-1:0] v, input logic [NB-1:0] t);
		list_answer_t a;
		logic [NB-1:0] made;
		logic handle_ok;
		a = '0;
		made = '0;
		handle_ok = (t == 0) || node_used[t];
		case (k)
			KIND_PUSH_BACK: a.status = link_before('0, v, made);
			KIND_PUSH_FRONT: a.status = link_before(next_of[0], v, made);
			KIND_POP_BACK: begin
				if (list_len == 0)
					a.status = ST_EMPTY;
				else
					a.removed_value = unlink_node(prev_of[0]);
			end
			KIND_POP_FRONT: begin
				if (list_len == 0)
					a.status = ST_EMPTY;
				else
					a.removed_value = unlink_node(next_of[0]);
			end
			KIND_INSERT_BEFORE: begin
				// the handle is judged before the pool
				if (!handle_ok)
					a.status = ST_BAD_NODE;
				else
					a.status = link_before(t, v, made);
			end
			KIND_ERASE: begin
				if (!handle_ok || t == 0)
					a.status = ST_BAD_NODE;
				else
					a.removed_value = unlink_node(t);
			end
			default: ;
		endcase
		a.new_node = made;
		a.element_count = NB'(list_len);
		return a;
	endfunction

	task automatic note_mismatch(input string what, input logic [DBITS-1:0] exp_v,
			input logic [DBITS-1:0] got_v);
		$display("%0t ns %s: expected %h got %h", $realtime, what, exp_v, got_v);
		mismatches++;
	endtask

	always @(negedge clk) begin
		list_answer_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_answers.size() == 0) begin
				note_mismatch("result with no request waiting", '0, '0);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.status)
					note_mismatch("status", DBITS'(want.status), DBITS'(status));
				if (new_node !== want.new_node)
					note_mismatch("new_node", DBITS'(want.new_node), DBITS'(new_node));
				if (removed_value !== want.removed_value)
					note_mismatch("removed_value", want.removed_value, removed_value);
				if (element_count !== want.element_count)
					note_mismatch("element_count", DBITS'(want.element_count),
						DBITS'(element_count));
			end
		end
	end

	// called at a rising edge; returns at the edge that takes the item
	task automatic issue_request(input logic [KIND_W-1:0] k, input logic [DBITS-1:0] v,
			input logic [NB-1:0] t);
		start <= 1'b1;
		kind <= k;
		value <= v;
		target_node <= t;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		pending_answers.push_back(apply_request(k, v, t));
	endtask

	task automatic sender_pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if ($urandom_range(0, 4) == 0)
			sender_pause($urandom_range(1, 6));
	endtask

	task automatic wait_for_answers();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [NB-1:0] pick_live_node();
		logic [NB-1:0] live[$];
		for (int i = 1; i < NODES; i++)
			if (node_used[i])
				live.push_back(NB'(i));
		if (live.size() == 0)
			return NB'($urandom_range(0, NODES - 1));
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	function automatic logic [DBITS-1:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		issue_request(KIND_POP_BACK, '0, '0);
		maybe_pause();
		issue_request(KIND_POP_FRONT, '1, '1);
		maybe_pause();
		issue_request(KIND_ERASE, 32'h0bad_0003, 4'd3);
		issue_request(KIND_INSERT_BEFORE, 32'h1234_5678, 4'd9);
		maybe_pause();
		issue_request(KIND_SPARE_A, 32'h5555_5555, 4'd5);
		issue_request(KIND_SPARE_B, 32'haaaa_aaaa, 4'd10);
	endtask

	task automatic test_link_moves();
		issue_request(KIND_PUSH_BACK, 32'h7fff_ffff, '0);
		issue_request(KIND_PUSH_FRONT, 32'h8000_0000, '0);
		maybe_pause();
		// insert before the sentinel appends at the back
		issue_request(KIND_INSERT_BEFORE, 32'hffff_ffff, 4'd0);
		issue_request(KIND_INSERT_BEFORE, '0, 4'd1);
		maybe_pause();
		issue_request(KIND_ERASE, '0, 4'd2);
		issue_request(KIND_POP_FRONT, '0, '0);
		issue_request(KIND_POP_BACK, '0, '0);
		maybe_pause();
	endtask

	task automatic test_full_pool();
		int turn;
		turn = 0;
		while (list_len < NODES - 1) begin
			issue_request(turn[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom, '0);
			turn++;
			maybe_pause();
		end
		issue_request(KIND_PUSH_BACK, 32'h0f0f_0f0f, '0);
		issue_request(KIND_INSERT_BEFORE, 32'hf0f0_f0f0, 4'd0);
		issue_request(KIND_ERASE, '0, 4'd0);
	endtask

	task automatic test_random_traffic();
		int roll;
		bit growing;
		logic [KIND_W-1:0] k;
		logic [NB-1:0] t;
		growing = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				growing = !growing;
			if (n == RANDOM_ITEMS / 2)
				wait_for_answers();
			roll = $urandom_range(0, 99);
			if (growing) begin
				if (roll < 30)
					k = KIND_PUSH_BACK;
				else if (roll < 50)
					k = KIND_PUSH_FRONT;
				else if (roll < 70)
					k = KIND_INSERT_BEFORE;
				else if (roll < 80)
					k = KIND_POP_BACK;
				else if (roll < 88)
					k = KIND_POP_FRONT;
				else if (roll < 97)
					k = KIND_ERASE;
				else
					k = roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
			end else begin
				if (roll < 10)
					k = KIND_PUSH_BACK;
				else if (roll < 20)
					k = KIND_PUSH_FRONT;
				else if (roll < 30)
					k = KIND_INSERT_BEFORE;
				else if (roll < 55)
					k = KIND_POP_BACK;
				else if (roll < 75)
					k = KIND_POP_FRONT;
				else if (roll < 97)
					k = KIND_ERASE;
				else
					k = roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
			end
			// mostly live handles, the rest anything including the sentinel
			if ($urandom_range(0, 4) != 0)
				t = pick_live_node();
			else
				t = NB'($urandom_range(0, NODES - 1));
			issue_request(k, pick_value(), t);
			if (n < RANDOM_ITEMS - CALM_TAIL)
				maybe_pause();
		end
	endtask

	initial begin
		for (int i = 0; i < NODES; i++) begin
			node_data[i] = '0;
			prev_of[i] = '0;
			next_of[i] = '0;
			node_used[i] = 1'b0;
		end
		list_len = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_link_moves();
		test_full_pool();
		test_random_traffic();
		wait_for_answers();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("doubly_linked_list_engine: match");
		else
			$display("doubly_linked_list_engine: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dlle_pkg.sv
rtl/dlle_ram.sv
rtl/dlle_front.sv
rtl/dlle_queue.sv
rtl/dlle_back.sv
rtl/doubly_linked_list_engine.sv
verif/testbench.sv
